// File: src/mprlb_pkg.sv
// Shared constants and types for the multi-port receive ring line buffer
`timescale 1ns / 1ps
package mprlb_pkg;
  localparam int DEF_RING_DEPTH = 256;
  localparam int DEF_NUM_PORTS = 3;
  localparam logic [2:0] KIND_PUSH = 3'd0;
  localparam logic [2:0] KIND_READ = 3'd1;
  localparam logic [2:0] KIND_LINE = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [6:0] LEN_CAP = 7'd64;
  localparam logic [6:0] LINE_MIN = 7'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] port;
    logic [7:0] rx_byte;
    logic [6:0] max_len;
  } cmd_t;
endpackage

// File: src/multi_port_rx_ring_line_buffer_core.sv
// Top level of the multi-port receive ring line buffer
// Push, clear, query and empty reads give a single result: the front end queues the command
// and the back end registers the result. Reads give one byte result per store read; a line
// read first scans up to the newline, one store read per byte, then reads the line again.
// Queue: up to two commands are queued; busy rises when the queue is full.
// Reset: synchronous rst clears pointers, counters and the queue; the store is not cleared.
// The receiver cannot stall: each result is valid for one cycle with strobe.
`timescale 1ns / 1ps
module multi_port_rx_ring_line_buffer_core import mprlb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int NUM_PORTS = DEF_NUM_PORTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [1:0]  port,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  max_len,
  output logic        strobe,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic        line_found,
  output logic [7:0]  available,
  output logic [15:0] drop_count,
  output logic        last
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  mprlb_front #(.NUM_PORTS(NUM_PORTS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .port(port),
    .rx_byte(rx_byte), .max_len(max_len), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  mprlb_back #(.RING_DEPTH(RING_DEPTH), .NUM_PORTS(NUM_PORTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .strobe(strobe), .data_byte(data_byte), .has_data(has_data), .line_found(line_found),
    .available(available), .drop_count(drop_count), .last(last)
  );
endmodule

// File: src/mprlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module mprlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/mprlb_front.sv
// Command front end: captures and filters commands into a short queue
`timescale 1ns / 1ps
module mprlb_front import mprlb_pkg::*; #(
  parameter int NUM_PORTS = DEF_NUM_PORTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  logic [1:0] port,
  input  logic [7:0] rx_byte,
  input  logic [6:0] max_len,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);
  // two-entry queue
  cmd_t       ent [2];
  logic [1:0] cnt;
  logic       rd_ptr, wr_ptr;
  logic       take, keep;
  cmd_t       c;

  assign busy = (cnt == 2'd2);
  assign take = start && !busy;
  always_comb begin
    c.kind = kind;
    c.port = {1'b0, port};
    c.rx_byte = rx_byte;
    c.max_len = (max_len > LEN_CAP) ? LEN_CAP : max_len;
  end
  // drop invalid ports and unknown kinds here
  assign keep = take && (int'(port) < NUM_PORTS) && (kind <= KIND_QUERY);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (keep) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, keep} - {1'b0, q_pop};
    end
    if (keep) ent[wr_ptr] <= c;
  end

  ap_no_over: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overfilled");
  ap_no_under: assert property (@(posedge clk) disable iff (rst) q_pop |-> cnt != 2'd0)
    else $error("pop from empty queue");
  ap_busy_full: assert property (@(posedge clk) disable iff (rst) busy |-> q_valid)
    else $error("busy with an empty queue");
endmodule

// File: src/mprlb_back.sv
// Command back end: ring pointers, store access and result sequencing
`timescale 1ns / 1ps
module mprlb_back import mprlb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int NUM_PORTS = DEF_NUM_PORTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        strobe,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic        line_found,
  output logic [7:0]  available,
  output logic [15:0] drop_count,
  output logic        last
);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int SW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int AW = $clog2(NUM_PORTS * RING_DEPTH);
  localparam logic [PW-1:0] PMAX = PW'(RING_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1; // look for a newline
  localparam logic [2:0] S_READ = 3'd2; // byte read, one byte per store read
  localparam logic [2:0] S_LINE = 3'd3; // consume line
  localparam logic [2:0] S_WAIT = 3'd4; // RAM latency

  logic [PW-1:0] wp [NUM_PORTS];
  logic [PW-1:0] rp [NUM_PORTS];
  logic [15:0]   dc [NUM_PORTS];

  logic [2:0]    state;
  logic [2:0]    resume;     // state entered once the store read lands
  cmd_t          cmd;
  logic [SW-1:0] sel;
  logic [PW-1:0] p;          // address issued this cycle
  logic [6:0]    k;          // byte results given so far
  logic          ram_we;
  logic [7:0]    rdata;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] v);
    return (v == PMAX) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [7:0] lvl(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [PW:0] n;
    n = (h >= t) ? {1'b0, h} - {1'b0, t} : (PW+1)'(RING_DEPTH) - {1'b0, t} + {1'b0, h};
    return (32'(n) > 32'd255) ? 8'hFF : 8'(n);
  endfunction

  logic [SW-1:0] qsel;
  assign qsel = SW'(q_cmd.port);

  logic [PW-1:0] wpq, rpq;
  assign wpq = wp[qsel];
  assign rpq = rp[qsel];

  // RAM addresses: push writes at the port's write pointer; reads use the current pointer p
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] rd_p;
  assign waddr = AW'(qsel) * AW'(RING_DEPTH) + AW'(wpq);

  mprlb_ram #(.WIDTH(8), .DEPTH(NUM_PORTS * RING_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(q_cmd.rx_byte),
    .raddr(raddr), .rdata(rdata)
  );

  logic [PW-1:0] rps;
  assign rps = rp[sel];

  always_comb begin
    rd_p = p;
    ram_we = 1'b0;
    q_pop = 1'b0;
    if (state == S_IDLE && q_valid) begin
      q_pop = 1'b1;
      if (q_cmd.kind == KIND_PUSH && adv(wpq) != rpq) ram_we = 1'b1;
    end
    raddr = AW'(sel) * AW'(RING_DEPTH) + AW'(rd_p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        wp[i] <= '0;
        rp[i] <= '0;
        dc[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            sel <= qsel;
            k <= '0;
            data_byte <= '0;
            has_data <= 1'b0;
            line_found <= 1'b0;
            last <= 1'b1;
            drop_count <= dc[qsel];
            available <= lvl(wpq, rpq);
            case (q_cmd.kind)
              KIND_PUSH: begin
                strobe <= 1'b1;
                if (adv(wpq) == rpq) begin
                  dc[qsel] <= dc[qsel] + 16'd1;
                  drop_count <= dc[qsel] + 16'd1;
                end else begin
                  wp[qsel] <= adv(wpq);
                  available <= lvl(adv(wpq), rpq);
                end
              end
              KIND_READ: begin
                if (rpq == wpq || q_cmd.max_len == '0) strobe <= 1'b1;
                else begin
                  p <= rpq;
                  state <= S_WAIT;
                  resume <= S_READ;
                end
              end
              KIND_LINE: begin
                if (rpq == wpq || q_cmd.max_len < LINE_MIN) strobe <= 1'b1;
                else begin
                  p <= rpq;
                  state <= S_WAIT;
                  resume <= S_SCAN;
                end
              end
              KIND_CLEAR: begin
                strobe <= 1'b1;
                wp[qsel] <= '0;
                rp[qsel] <= '0;
                dc[qsel] <= '0;
                drop_count <= '0;
                available <= '0;
              end
              default: strobe <= 1'b1;
            endcase
          end
        end
        default: ;
      endcase
      if (state != S_IDLE) begin
        // rdata holds the byte at address p issued the cycle before
        case (state)
          S_WAIT: begin
            // address p now presented; data comes next cycle
            state <= resume;
          end
          S_READ: begin
            strobe <= 1'b1;
            data_byte <= rdata;
            has_data <= 1'b1;
            line_found <= 1'b0;
            rp[sel] <= adv(p);
            available <= lvl(wp[sel], adv(p));
            k <= k + 7'd1;
            if (adv(p) == wp[sel] || k + 7'd1 == cmd.max_len) begin
              last <= 1'b1;
              state <= S_IDLE;
            end else begin
              last <= 1'b0;
              p <= adv(p);
              state <= S_WAIT;
              resume <= S_READ;
            end
          end
          S_SCAN: begin
            if (rdata == CH_LF) begin
              p <= rps;
              state <= S_WAIT;
              resume <= S_LINE;
            end else if (adv(p) == wp[sel]) begin
              strobe <= 1'b1;
              last <= 1'b1;
              state <= S_IDLE;
            end else begin
              p <= adv(p);
              state <= S_WAIT;
              resume <= S_SCAN;
            end
          end
          S_LINE: begin
            rp[sel] <= adv(p);
            if (rdata == CH_LF) begin
              strobe <= 1'b1;
              data_byte <= '0;
              has_data <= 1'b0;
              line_found <= 1'b1;
              last <= 1'b1;
              available <= lvl(wp[sel], adv(p));
              state <= S_IDLE;
            end else begin
              if (rdata != CH_CR && k < cmd.max_len - 7'd1) begin
                strobe <= 1'b1;
                data_byte <= rdata;
                has_data <= 1'b1;
                line_found <= 1'b1;
                last <= 1'b0;
                available <= lvl(wp[sel], adv(p));
                k <= k + 7'd1;
              end
              p <= adv(p);
              state <= S_WAIT;
              resume <= S_LINE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  ap_ret_idle: assert property (@(posedge clk) disable iff (rst)
      (strobe && last) |-> state == S_IDLE)
    else $error("bad state after final result");
  ap_pop_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |-> state == S_IDLE)
    else $error("command taken while busy");
  ap_data_flag: assert property (@(posedge clk) disable iff (rst)
      (strobe && has_data && state == S_IDLE) |-> last)
    else $error("byte result ended run without last");
endmodule
